>>> sv/p3ts_pkg.sv
package p3ts_pkg;

    localparam int MAX_POSITIONS_DEF = 2048;
    localparam int FIELD_BITS = 3;
    localparam int BYTE_W = 8;
    localparam int POS_W = 11;
    localparam int ROWS_W = 7;
    localparam int COLS_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int GEN_W = 32;

    localparam logic [GEN_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [GEN_W-1:0] LCG_INC = 32'd12345;
    localparam int RAND_LSB = 16;
    localparam int RAND_W = 15;

    // Reciprocal of six, scaled by two to the power RECIP6_SHIFT.
    localparam int RECIP6_SHIFT = 18;
    localparam logic [16:0] RECIP6 = 17'd43691;
    localparam logic [RAND_W-1:0] RAND_DIV = 15'd6;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_FILL  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        REG_ROWS    = 2'd0,
        REG_COLUMNS = 2'd1,
        REG_SEED    = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_FILL,
        ST_FLUSH
    } state_t;

endpackage

>>> sv/p3ts_bank.sv
module p3ts_bank #(
    parameter int DEPTH = 384,
    parameter int ADDR_W = 9,
    parameter int WIDTH = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/packed_3bit_tile_store_core.sv
// Packed store of 3-bit entries held in a byte memory, split into an even-byte
// bank and an odd-byte bank so that an entry that straddles two bytes is
// reached in one memory access.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets the
// rows, the columns and the generator seed; it is always ready. The user must
// write it only while the block is idle; the block itself does not enforce it.
// Request channel (in_valid, in_ready, func, position, value) takes a read, a
// write or a random fill. Result channel (out_valid, out_ready, entry,
// out_of_range) returns exactly one result per request.
// A read or a write passes through the synchronous bank read and then a step
// that extracts the entry, writes back both bytes for a write and registers
// the result. A fill handles one position per cycle for the N positions in
// use, the generator multiply feeding the byte assembler. After reset the
// block clears both banks, one address per cycle, over all of each bank's
// (ceil(MAX_POSITIONS * 3 / 8) + 1) / 2 addresses (384 at the default size),
// and holds in_ready low meanwhile. A request is taken only while the result
// register is empty or being drained, so a stalled receiver holds the block
// idle.
module packed_3bit_tile_store_core #(
    parameter int MAX_POSITIONS = p3ts_pkg::MAX_POSITIONS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [p3ts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [p3ts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       func,
    input  logic [p3ts_pkg::POS_W-1:0]       position,
    input  logic [p3ts_pkg::FIELD_BITS-1:0]  value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [p3ts_pkg::FIELD_BITS-1:0]  entry,
    output logic                             out_of_range
);

    localparam int FB = p3ts_pkg::FIELD_BITS;
    localparam int BW = p3ts_pkg::BYTE_W;
    localparam int STORE_BYTES = (MAX_POSITIONS * FB + 7) / 8;
    localparam int BANK_DEPTH = (STORE_BYTES + 1) / 2;
    localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int TOT_W = $clog2(MAX_POSITIONS + 1);
    localparam int PROD_W = p3ts_pkg::ROWS_W + p3ts_pkg::COLS_W;
    localparam int CMP_W = (PROD_W > TOT_W) ? PROD_W : TOT_W;
    localparam int BIT_W = p3ts_pkg::POS_W + 2;
    localparam int IDX_W = BIT_W - 3;
    localparam int BIDX_W = $clog2(STORE_BYTES + 1);
    localparam int ACC_W = BW + FB;
    localparam logic [p3ts_pkg::GEN_W-1:0] GEN_ONE = 32'd1;

    typedef logic [BANK_AW-1:0] bank_addr_t;

    p3ts_pkg::state_t state_reg, state_next;

    logic [BANK_AW-1:0]              clr_addr_reg;
    logic [p3ts_pkg::ROWS_W-1:0]     rows_reg;
    logic [p3ts_pkg::COLS_W-1:0]     cols_reg;
    logic [p3ts_pkg::GEN_W-1:0]      gen_reg, gen_next;
    logic [TOT_W-1:0]                gen_cnt_reg;
    logic                            gen_fresh_reg;
    logic [BW-1:0]                   acc_reg;
    logic [2:0]                      acc_bits_reg;
    logic [BIDX_W-1:0]               byte_idx_reg;
    logic [TOT_W-1:0]                total_reg;

    logic [1:0]                      req_func_reg;
    logic                            req_oor_reg;
    logic [2:0]                      req_sh_reg;
    logic                            req_odd_reg;
    logic                            req_hi_ok_reg;
    logic [FB-1:0]                   req_val_reg;
    logic [BANK_AW-1:0]              req_lo_addr_reg;
    logic [BANK_AW-1:0]              req_hi_addr_reg;

    logic                            out_valid_reg;
    logic [FB-1:0]                   entry_reg;
    logic                            oor_reg;

    logic [PROD_W-1:0]               prod;
    logic [TOT_W-1:0]                total;
    logic                            pos_oor;
    logic [BIT_W-1:0]                bit_idx;
    logic [IDX_W-1:0]                idx;
    logic [IDX_W-1:0]                half_idx;
    logic [BANK_AW-1:0]              lo_addr;
    logic [BANK_AW-1:0]              hi_addr;
    logic                            hi_ok;
    logic                            accept;

    logic                            a_we, b_we;
    logic [BANK_AW-1:0]              a_waddr, b_waddr, a_raddr, b_raddr;
    logic [BW-1:0]                   a_wdata, b_wdata, a_rdata, b_rdata;

    logic [BW-1:0]                   lo_byte, hi_byte;
    logic [2*BW-1:0]                 word, mask, new_word;
    logic [FB-1:0]                   extracted;
    logic                            do_write;
    logic                            load_result;
    logic [FB-1:0]                   result_entry;
    logic                            result_oor;

    logic [p3ts_pkg::RAND_W-1:0]     rnd;
    logic [31:0]                     recip_prod;
    logic [p3ts_pkg::RAND_W-1:0]     quot;
    logic [p3ts_pkg::RAND_W-1:0]     rem_full;
    logic [FB-1:0]                   rand_val;
    logic [ACC_W-1:0]                acc_w;
    logic [3:0]                      bits_w;
    logic                            byte_done;
    logic                            gen_more;
    logic                            fill_done;
    logic                            fill_wr;
    logic [BW-1:0]                   fill_data;
    logic                            clr_last;

    assign cfg_ready = 1'b1;

    assign prod = PROD_W'(rows_reg) * PROD_W'(cols_reg);
    assign total = (CMP_W'(prod) > CMP_W'(MAX_POSITIONS)) ? TOT_W'(MAX_POSITIONS) : TOT_W'(prod);
    assign pos_oor = CMP_W'(position) >= CMP_W'(total);

    assign bit_idx = BIT_W'({position, 1'b0}) + BIT_W'(position);
    assign idx = bit_idx[BIT_W-1:3];
    assign half_idx = idx >> 1;
    assign lo_addr = bank_addr_t'(half_idx);
    assign hi_addr = bank_addr_t'(half_idx + IDX_W'(1));
    assign hi_ok = (32'(idx) + 32'd1) < 32'(STORE_BYTES);

    assign accept = in_valid && in_ready;

    assign a_raddr = idx[0] ? hi_addr : lo_addr;
    assign b_raddr = lo_addr;

    assign lo_byte = req_odd_reg ? b_rdata : a_rdata;
    assign hi_byte = !req_hi_ok_reg ? '0 : (req_odd_reg ? a_rdata : b_rdata);
    assign word = {hi_byte, lo_byte};
    assign mask = (2*BW)'({FB{1'b1}}) << req_sh_reg;
    assign new_word = (word & ~mask) | ((2*BW)'(req_val_reg) << req_sh_reg);
    assign extracted = FB'(word >> req_sh_reg);
    assign do_write = (req_func_reg == p3ts_pkg::FUNC_WRITE) && !req_oor_reg;

    assign rnd = gen_reg[p3ts_pkg::RAND_LSB +: p3ts_pkg::RAND_W];
    assign recip_prod = 32'(rnd) * 32'(p3ts_pkg::RECIP6);
    assign quot = p3ts_pkg::RAND_W'(recip_prod >> p3ts_pkg::RECIP6_SHIFT);
    assign rem_full = rnd - quot * p3ts_pkg::RAND_DIV;
    assign rand_val = rem_full[FB-1:0] + FB'(1);

    assign acc_w = ACC_W'(acc_reg) | (ACC_W'(rand_val) << acc_bits_reg);
    assign bits_w = 4'(acc_bits_reg) + 4'(FB);
    assign byte_done = gen_fresh_reg && bits_w[3];
    assign gen_more = gen_cnt_reg != total_reg;
    assign fill_done = !gen_more && !gen_fresh_reg;
    assign clr_last = clr_addr_reg == BANK_AW'(BANK_DEPTH - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            p3ts_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = p3ts_pkg::ST_IDLE;
                end
            end
            p3ts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == p3ts_pkg::FUNC_FILL)
                    begin
                        state_next = p3ts_pkg::ST_FILL;
                    end
                    else
                    begin
                        state_next = p3ts_pkg::ST_ACCESS;
                    end
                end
            end
            p3ts_pkg::ST_ACCESS:
            begin
                state_next = p3ts_pkg::ST_IDLE;
            end
            p3ts_pkg::ST_FILL:
            begin
                if (fill_done)
                begin
                    state_next = p3ts_pkg::ST_FLUSH;
                end
            end
            p3ts_pkg::ST_FLUSH:
            begin
                state_next = p3ts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = p3ts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        a_we = 1'b0;
        b_we = 1'b0;
        a_waddr = lo_addr;
        b_waddr = lo_addr;
        a_wdata = '0;
        b_wdata = '0;
        fill_wr = 1'b0;
        fill_data = acc_w[BW-1:0];
        load_result = 1'b0;
        result_entry = '0;
        result_oor = 1'b0;
        unique case (state_reg)
            p3ts_pkg::ST_CLEAR:
            begin
                a_we = 1'b1;
                b_we = 1'b1;
                a_waddr = clr_addr_reg;
                b_waddr = clr_addr_reg;
            end
            p3ts_pkg::ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
            end
            p3ts_pkg::ST_ACCESS:
            begin
                load_result = 1'b1;
                result_oor = req_oor_reg;
                if ((req_func_reg == p3ts_pkg::FUNC_READ) && !req_oor_reg)
                begin
                    result_entry = extracted;
                end
                a_waddr = req_odd_reg ? req_hi_addr_reg : req_lo_addr_reg;
                b_waddr = req_lo_addr_reg;
                a_wdata = req_odd_reg ? new_word[2*BW-1:BW] : new_word[BW-1:0];
                b_wdata = req_odd_reg ? new_word[BW-1:0] : new_word[2*BW-1:BW];
                a_we = do_write && (req_odd_reg ? req_hi_ok_reg : 1'b1);
                b_we = do_write && (req_odd_reg ? 1'b1 : req_hi_ok_reg);
            end
            p3ts_pkg::ST_FILL:
            begin
                fill_wr = byte_done;
                fill_data = acc_w[BW-1:0];
            end
            p3ts_pkg::ST_FLUSH:
            begin
                load_result = 1'b1;
                fill_wr = acc_bits_reg != 3'd0;
                fill_data = acc_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        if (fill_wr)
        begin
            a_waddr = bank_addr_t'(byte_idx_reg >> 1);
            b_waddr = bank_addr_t'(byte_idx_reg >> 1);
            a_wdata = fill_data;
            b_wdata = fill_data;
            a_we = !byte_idx_reg[0];
            b_we = byte_idx_reg[0];
        end
    end

    always_comb
    begin
        gen_next = gen_reg;
        if (cfg_valid && cfg_ready && (cfg_index == p3ts_pkg::REG_SEED))
        begin
            gen_next = cfg_data;
        end
        else if ((state_reg == p3ts_pkg::ST_FILL) && gen_more)
        begin
            gen_next = gen_reg * p3ts_pkg::LCG_MUL + p3ts_pkg::LCG_INC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= p3ts_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            rows_reg <= '0;
            cols_reg <= '0;
            gen_reg <= GEN_ONE;
            gen_cnt_reg <= '0;
            gen_fresh_reg <= 1'b0;
            acc_reg <= '0;
            acc_bits_reg <= '0;
            byte_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg <= gen_next;
            if (state_reg == p3ts_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + BANK_AW'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == p3ts_pkg::REG_ROWS)
                begin
                    rows_reg <= cfg_data[p3ts_pkg::ROWS_W-1:0];
                end
                else if (cfg_index == p3ts_pkg::REG_COLUMNS)
                begin
                    cols_reg <= cfg_data[p3ts_pkg::COLS_W-1:0];
                end
            end
            if (accept && (func == p3ts_pkg::FUNC_FILL))
            begin
                gen_cnt_reg <= '0;
                gen_fresh_reg <= 1'b0;
                acc_reg <= '0;
                acc_bits_reg <= '0;
                byte_idx_reg <= '0;
            end
            else if (state_reg == p3ts_pkg::ST_FILL)
            begin
                gen_fresh_reg <= gen_more;
                if (gen_more)
                begin
                    gen_cnt_reg <= gen_cnt_reg + TOT_W'(1);
                end
                if (gen_fresh_reg)
                begin
                    acc_bits_reg <= bits_w[2:0];
                    acc_reg <= byte_done ? BW'(acc_w >> BW) : acc_w[BW-1:0];
                end
                if (byte_done)
                begin
                    byte_idx_reg <= byte_idx_reg + BIDX_W'(1);
                end
            end
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_func_reg <= func;
            req_oor_reg <= ((func == p3ts_pkg::FUNC_READ) || (func == p3ts_pkg::FUNC_WRITE))
                           && pos_oor;
            req_sh_reg <= bit_idx[2:0];
            req_odd_reg <= idx[0];
            req_hi_ok_reg <= hi_ok;
            req_val_reg <= value;
            req_lo_addr_reg <= lo_addr;
            req_hi_addr_reg <= hi_addr;
            total_reg <= total;
        end
        if (load_result)
        begin
            entry_reg <= result_entry;
            oor_reg <= result_oor;
        end
    end

    p3ts_bank #(
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (BANK_AW),
        .WIDTH  (BW)
    ) u_even_bank (
        .clk     (clk),
        .wr_en   (a_we),
        .wr_addr (a_waddr),
        .wr_data (a_wdata),
        .rd_addr (a_raddr),
        .rd_data (a_rdata)
    );

    p3ts_bank #(
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (BANK_AW),
        .WIDTH  (BW)
    ) u_odd_bank (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (b_wdata),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    assign out_valid = out_valid_reg;
    assign entry = entry_reg;
    assign out_of_range = oor_reg;

endmodule
